// ===== design/mavg_pkg.sv =====
// shared constants for the three-axis moving average filter
package mavg_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int AXES       = 3;
    localparam int DATA_W     = AXES * SAMPLE_W;
    localparam int WINDOW_DEF = 10;

endpackage

// ===== design/mavg_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
module mavg_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/mavg_div.sv =====
// bit-serial restoring divider, signed dividend by small unsigned divisor, truncating
module mavg_div
    import mavg_pkg::*;
#(
    parameter int SUM_W = 20,
    parameter int DIV_W = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [SUM_W-1:0]    i_dividend,
    input  logic [DIV_W-1:0]           i_divisor,
    output logic                       o_done,
    output logic signed [SAMPLE_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    logic [SUM_W-1:0] r_quo;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_dvs;

    logic [DIV_W:0]   n_rem_sh;
    logic             n_fits;
    logic [DIV_W:0]   n_rem_sub;
    logic [SUM_W-1:0] n_mag;
    logic [SUM_W-1:0] n_quo_neg;

    always_comb begin
        n_rem_sh  = {r_rem, r_quo[SUM_W-1]};
        n_fits    = (n_rem_sh >= {1'b0, r_dvs});
        n_rem_sub = n_rem_sh - {1'b0, r_dvs};
        n_mag     = i_dividend[SUM_W-1] ? (SUM_W'(0) - SUM_W'(i_dividend))
                                        : SUM_W'(i_dividend);
        n_quo_neg = SUM_W'(0) - r_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SUM_W-1];
            r_quo <= n_mag;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_fits ? n_rem_sub[DIV_W-1:0] : n_rem_sh[DIV_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], n_fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? n_quo_neg[SAMPLE_W-1:0] : r_quo[SAMPLE_W-1:0];

endmodule

// ===== design/moving_average_warmup_3axis_top.sv =====
// Three-axis boxcar moving average over the last WINDOW samples, with warm-up
// averaging over the samples seen so far until the ring has filled. Samples are
// signed 16-bit raw counts and averages truncate toward zero. The sample ring sits
// in a block ram; running sums sit in registers. One transaction is taken at a
// time. Each result passes through the read, start, divide and output states into
// the output register. Three bit-serial dividers, one per axis, run in parallel, each
// producing one quotient bit per cycle. The next input is accepted once the result
// is in the output register.
module moving_average_warmup_3axis_top
    import mavg_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [DATA_W-1:0] i_s_axis_tdata,  // accel_x, accel_y, accel_z
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [DATA_W-1:0] o_m_axis_tdata   // avg_x, avg_y, avg_z
);

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
    localparam int DIV_W  = $clog2(WINDOW + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_START,
        S_DIV,
        S_OUT
    } t_state;

    t_state                   r_state;
    logic [DATA_W-1:0]        r_in;
    logic [SLOT_W-1:0]        r_slot;
    logic                     r_full;
    logic signed [SUM_W-1:0]  r_sum [AXES];
    logic [DIV_W-1:0]         r_div;
    logic                     r_m_valid;
    logic [DATA_W-1:0]        r_m_data;

    logic                     n_s_accept;
    logic [DATA_W-1:0]        n_rd_data;
    logic signed [SUM_W-1:0]  n_sum [AXES];
    logic [SLOT_W-1:0]        n_slot;
    logic                     n_wrap;
    logic [AXES-1:0]          n_div_done;
    logic [DATA_W-1:0]        n_quot;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign n_s_accept      = i_s_axis_tvalid && o_s_axis_tready;

    mavg_ram #(
        .WIDTH  (DATA_W),
        .DEPTH  (WINDOW),
        .ADDR_W (SLOT_W)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == S_READ),
        .i_wr_addr (r_slot),
        .i_wr_data (r_in),
        .i_rd_en   (n_s_accept),
        .i_rd_addr (r_slot),
        .o_rd_data (n_rd_data)
    );

    always_comb begin
        n_wrap = (r_slot == SLOT_W'(WINDOW - 1));
        n_slot = n_wrap ? '0 : r_slot + SLOT_W'(1);
        for (int a = 0; a < AXES; a++) begin
            n_sum[a] = r_sum[a]
                     - (r_full ? SUM_W'($signed(n_rd_data[a*SAMPLE_W +: SAMPLE_W])) : '0)
                     + SUM_W'($signed(r_in[a*SAMPLE_W +: SAMPLE_W]));
        end
    end

    for (genvar a = 0; a < AXES; a++) begin : g_axis
        mavg_div #(
            .SUM_W (SUM_W),
            .DIV_W (DIV_W)
        ) u_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (r_state == S_START),
            .i_dividend (r_sum[a]),
            .i_divisor  (r_div),
            .o_done     (n_div_done[a]),
            .o_quot     (n_quot[a*SAMPLE_W +: SAMPLE_W])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_slot    <= '0;
            r_full    <= 1'b0;
            r_m_valid <= 1'b0;
            for (int a = 0; a < AXES; a++) begin
                r_sum[a] <= '0;
            end
        end else begin
            if (r_m_valid && i_m_axis_tready && (r_state != S_OUT)) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (n_s_accept) begin
                        r_in    <= i_s_axis_tdata;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    for (int a = 0; a < AXES; a++) begin
                        r_sum[a] <= n_sum[a];
                    end
                    r_slot <= n_slot;
                    if (n_wrap) begin
                        r_full <= 1'b1;
                    end
                    r_div   <= (r_full || n_wrap) ? DIV_W'(WINDOW)
                                                  : DIV_W'(r_slot) + DIV_W'(1);
                    r_state <= S_START;
                end
                S_START: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (&n_div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_m_valid || i_m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= n_quot;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

endmodule

// ===== design/mavg_chk.sv =====
// port-level checks for the moving average filter, bound to the top level
module mavg_chk
    import mavg_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_s_axis_tvalid,
    input logic              o_s_axis_tready,
    input logic [DATA_W-1:0] i_s_axis_tdata,
    input logic              o_m_axis_tvalid,
    input logic              i_m_axis_tready,
    input logic [DATA_W-1:0] o_m_axis_tdata
);

    logic n_s_accept;
    assign n_s_accept = i_s_axis_tvalid && o_s_axis_tready;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled output transaction changed");

    // one transaction in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_s_accept |=> !o_s_axis_tready)
        else $error("input accepted while a transaction is in flight");

    // a result never appears straight after an input transaction
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> !$past(n_s_accept))
        else $error("result appeared without divider latency");

    // ready is low while a result is being formed
    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_s_accept |=> ##1 !o_s_axis_tready)
        else $error("input ready during processing");

endmodule

bind moving_average_warmup_3axis_top mavg_chk u_mavg_chk (.*);

// ===== sim/mavg_average_check.sv =====
`timescale 1ns / 100ps
// transaction monitor and window average predictor for the three-axis filter
module mavg_average_check
    import mavg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_tvalid,
    input  logic              i_in_tready,
    input  logic [DATA_W-1:0] i_in_tdata,   // accel_x, accel_y, accel_z
    input  logic              i_out_tvalid,
    input  logic              i_out_tready,
    input  logic [DATA_W-1:0] i_out_tdata,  // avg_x, avg_y, avg_z
    output int                o_mismatches,
    output int                o_pending
);

    logic signed [SAMPLE_W-1:0] window_ring [WINDOW_DEF][AXES];
    int                         axis_sums [AXES];
    int                         next_slot;
    bit                         ring_filled;
    logic [DATA_W-1:0]          expected_avgs [$];
    int                         fails;

    initial begin
        for (int s = 0; s < WINDOW_DEF; s++) begin
            for (int a = 0; a < AXES; a++) begin
                window_ring[s][a] = '0;
            end
        end
        for (int a = 0; a < AXES; a++) begin
            axis_sums[a] = 0;
        end
        next_slot    = 0;
        ring_filled  = 1'b0;
        fails        = 0;
    end

    task automatic next_window_average(input logic [DATA_W-1:0] samples,
                                       output logic [DATA_W-1:0] averages);
        logic signed [SAMPLE_W-1:0] fresh;
        int                         divisor;
        for (int a = 0; a < AXES; a++) begin
            fresh        = samples[a*SAMPLE_W +: SAMPLE_W];
            axis_sums[a] = axis_sums[a] - window_ring[next_slot][a] + fresh;
            window_ring[next_slot][a] = fresh;
        end
        next_slot = (next_slot + 1) % WINDOW_DEF;
        if (next_slot == 0) begin
            ring_filled = 1'b1;
        end
        divisor = ring_filled ? WINDOW_DEF : next_slot;
        for (int a = 0; a < AXES; a++) begin
            averages[a*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'(axis_sums[a] / divisor);
        end
    endtask

    always @(posedge i_clk) begin
        logic [DATA_W-1:0] want;
        if (i_rst_n) begin
            if (i_in_tvalid && i_in_tready) begin
                next_window_average(i_in_tdata, want);
                expected_avgs.push_back(want);
            end
            if (i_out_tvalid && i_out_tready) begin
                if (expected_avgs.size() == 0) begin
                    $error("result with no sample outstanding: %h", i_out_tdata);
                    fails++;
                end else begin
                    want = expected_avgs.pop_front();
                    for (int a = 0; a < AXES; a++) begin
                        if (want[a*SAMPLE_W +: SAMPLE_W] !== i_out_tdata[a*SAMPLE_W +: SAMPLE_W]) begin
                            $error("%s: expected %0d, got %0d",
                                   (a == 0) ? "avg_x" : (a == 1) ? "avg_y" : "avg_z",
                                   $signed(want[a*SAMPLE_W +: SAMPLE_W]),
                                   $signed(i_out_tdata[a*SAMPLE_W +: SAMPLE_W]));
                            fails++;
                        end
                    end
                end
            end
        end
        o_pending    <= expected_avgs.size();
        o_mismatches <= fails;
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// stimulus, flow control and verdict for the three-axis moving average filter
module tb_top;
    import mavg_pkg::*;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    int                mismatches;
    int                pending;

    int                in_idle_pct   = 0;
    int                out_idle_pct  = 0;
    int                hold_requests = 0;

    always #10 clk = ~clk;

    moving_average_warmup_3axis_top i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    mavg_average_check u_avg_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_tvalid  (s_tvalid),
        .i_in_tready  (s_tready),
        .i_in_tdata   (s_tdata),
        .i_out_tvalid (m_tvalid),
        .i_out_tready (m_tready),
        .i_out_tdata  (m_tdata),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    task automatic send_sample(input logic [SAMPLE_W-1:0] x, input logic [SAMPLE_W-1:0] y,
                               input logic [SAMPLE_W-1:0] z);
        while ($urandom_range(99) < in_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        do @(posedge clk); while (!s_tready);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2, 3, 4: return SAMPLE_W'(int'($urandom_range(20)) - 10);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++) begin
            send_sample(pick_sample(), pick_sample(), pick_sample());
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // receiver flow control, with a long hold-off on request
    initial begin
        int hold_left;
        int hold_served;
        hold_left   = 0;
        hold_served = 0;
        forever begin
            @(posedge clk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = 300;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= out_idle_pct);
            end
        end
    end

    initial begin
        in_idle_pct  = 17;
        out_idle_pct = 80;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // warm-up and ring fill with full-scale samples, then the opposite extremes
        for (int i = 0; i < 10; i++) begin
            send_sample(16'h7FFF, 16'h8000, (i % 2) ? -16'sd7 : 16'sd5);
        end
        for (int i = 0; i < 10; i++) begin
            send_sample(16'h8000, 16'h7FFF, (i % 2) ? 16'sd3 : -16'sd1);
        end
        // small samples, some negative, into a window still holding the extremes; truncation toward zero
        for (int i = 0; i < 4; i++) begin
            send_sample(-16'sd1, 16'sd1, (i % 2) ? -16'sd3 : 16'sd0);
        end

        send_random(310);
        wait_drained();

        in_idle_pct  = 80;
        out_idle_pct = 17;
        send_random(310);

        in_idle_pct  = 0;
        out_idle_pct = 0;
        hold_requests++;
        send_random(306);

        wait_drained();
        repeat (60) @(posedge clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
